FILE: hw/rtl/bcd_pkg.sv
package bcd_pkg;

    localparam int unsigned DEF_CACHE_SLOTS       = 64;
    localparam int unsigned DEF_FILE_ID_BITS      = 8;
    localparam int unsigned DEF_BLOCK_NUMBER_BITS = 32;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;
    localparam logic [1:0] REQ_CLOSE = 2'd3;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_ONE  = 16'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  file_id;
        logic [31:0] block_number;
        logic        full_block;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  slot;
        logic        need_fill;
        logic        writeback_needed;
        logic [7:0]  writeback_file;
        logic [31:0] writeback_block;
        logic        last;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic victim_prep;
        logic access;
        logic flush_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic flush_done;
    } stat_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] sh;
        sh = s >> 1;
        return s[0] ? (sh ^ LFSR_TAPS) : sh;
    endfunction

endpackage

FILE: hw/rtl/block_cache_directory_random_replace.sv
// a read or write access steps through capture, victim prep and access; its result is registered after the access step
// flush and close give one result per dirty slot of the file, one per cycle (one if none).
// a new request is taken only while the block is idle, after the last step of the one before
// the pace of reads and writes is set by the two-step victim remainder and the single directory write port
// results are strobed for one cycle on result_valid; the receiver cannot stall
// reset: all slots invalid and clean, random generator loaded with 1, block idle
module block_cache_directory_random_replace import bcd_pkg::*;
#(
    parameter int unsigned CACHE_SLOTS       = DEF_CACHE_SLOTS,
    parameter int unsigned FILE_ID_BITS      = DEF_FILE_ID_BITS,
    parameter int unsigned BLOCK_NUMBER_BITS = DEF_BLOCK_NUMBER_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request beat, taken when start is high and busy low
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    // seed register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // result beats, one cycle each
    output logic        result_valid,
    output rsp_t        result
);

    cmd_t  cmd;
    stat_t stat;

    // the seed register is always writable; the block does not hold off a write while busy
    assign cfg_ready = 1'b1;

    bcd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_type (req.req_type),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy)
    );

    // directory: valid/dirty bits, tags, victim generator and result register
    bcd_dpath #(
        .CACHE_SLOTS       (CACHE_SLOTS),
        .FILE_ID_BITS      (FILE_ID_BITS),
        .BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req          (req),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // a result beat always follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without work in progress");

    // an accepted request keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

    // a hit is a single final result with no write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.hit) |-> (result.last && !result.writeback_needed))
        else $error("bad hit result");

    // unused write-back fields stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.writeback_needed) |->
            (result.writeback_file == '0 && result.writeback_block == '0))
        else $error("stray write-back fields");

endmodule

FILE: hw/rtl/bcd_ctrl.sv
module bcd_ctrl import bcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] start_type,
    input  stat_t      stat,
    output cmd_t       cmd,
    output logic       busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_ACC   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (start_type inside {REQ_FLUSH, REQ_CLOSE}) ? ST_FLUSH
                                                                              : ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.victim_prep = 1'b1;
                state_next      = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.access = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                cmd.flush_step = 1'b1;
                if (stat.flush_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: hw/rtl/bcd_dpath.sv
module bcd_dpath import bcd_pkg::*;
#(
    parameter int unsigned CACHE_SLOTS       = DEF_CACHE_SLOTS,
    parameter int unsigned FILE_ID_BITS      = DEF_FILE_ID_BITS,
    parameter int unsigned BLOCK_NUMBER_BITS = DEF_BLOCK_NUMBER_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  req_t        req,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output rsp_t        result
);

    localparam int unsigned SlotW  = $clog2(CACHE_SLOTS);
    localparam int unsigned RecipK = 24;
    localparam int unsigned Recip  = ((1 << RecipK) + CACHE_SLOTS - 1) / CACHE_SLOTS;

    logic [1:0]                   type_reg;
    logic [FILE_ID_BITS-1:0]      file_reg;
    logic [BLOCK_NUMBER_BITS-1:0] block_reg;
    logic                         full_reg;

    logic [CACHE_SLOTS-1:0]       valid_reg, valid_next;
    logic [CACHE_SLOTS-1:0]       dirty_reg, dirty_next;
    logic [FILE_ID_BITS-1:0]      ftag_reg [CACHE_SLOTS];
    logic [BLOCK_NUMBER_BITS-1:0] btag_reg [CACHE_SLOTS];
    logic [15:0]                  lfsr_reg, lfsr_next;
    logic [15:0]                  quot_reg;
    rsp_t                         out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic [CACHE_SLOTS-1:0] fmatch, hit_vec, pend;
    logic [SlotW-1:0]       hit_idx, free_idx, pend_idx, victim, sel_idx;
    logic                   hit_any, all_valid, pend_none, pend_one, tag_we;
    logic [15:0]            stepped, rem16;
    logic [RecipK+15:0]     prod;

    always_comb
    begin
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            fmatch[i]  = valid_reg[i] && (ftag_reg[i] == file_reg);
            hit_vec[i] = fmatch[i] && (btag_reg[i] == block_reg);
            pend[i]    = fmatch[i] && dirty_reg[i];
        end
        hit_idx  = '0;
        free_idx = '0;
        pend_idx = '0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])    hit_idx  = SlotW'(i);
            if (!valid_reg[i]) free_idx = SlotW'(i);
            if (pend[i])       pend_idx = SlotW'(i);
        end
    end

    assign hit_any   = |hit_vec;
    assign all_valid = &valid_reg;
    assign pend_none = (pend == '0);
    assign pend_one  = ((pend & (pend - CACHE_SLOTS'(1))) == '0);

    // victim = stepped mod slots, by reciprocal multiply: quotient registered in prep, remainder taken in access
    assign stepped = lfsr_step(lfsr_reg);
    assign prod    = (RecipK+16)'(stepped) * (RecipK+16)'(Recip);
    assign rem16   = stepped - 16'(quot_reg * 16'(CACHE_SLOTS));
    assign victim  = SlotW'(rem16);

    assign stat.flush_done = pend_one;

    always_comb
    begin
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        lfsr_next      = lfsr_reg;
        out_next       = '0;
        out_valid_next = 1'b0;
        tag_we         = 1'b0;
        sel_idx        = all_valid ? victim : free_idx;

        if (cmd.access)
        begin
            out_valid_next = 1'b1;
            out_next.last  = 1'b1;
            if (hit_any)
            begin
                out_next.hit  = 1'b1;
                out_next.slot = 6'(hit_idx);
                if (type_reg == REQ_WRITE)
                begin
                    dirty_next[hit_idx] = 1'b1;
                end
            end
            else
            begin
                tag_we                  = 1'b1;
                out_next.slot           = 6'(sel_idx);
                out_next.need_fill      = (type_reg == REQ_WRITE) ? !full_reg : 1'b1;
                valid_next[sel_idx]     = 1'b1;
                dirty_next[sel_idx]     = (type_reg == REQ_WRITE);
                if (all_valid)
                begin
                    lfsr_next = stepped;
                    if (dirty_reg[victim])
                    begin
                        out_next.writeback_needed = 1'b1;
                        out_next.writeback_file   = 8'(ftag_reg[victim]);
                        out_next.writeback_block  = 32'(btag_reg[victim]);
                    end
                end
            end
        end

        if (cmd.flush_step)
        begin
            out_valid_next = 1'b1;
            out_next.last  = pend_one;
            if (!pend_none)
            begin
                out_next.slot             = 6'(pend_idx);
                out_next.writeback_needed = 1'b1;
                out_next.writeback_file   = 8'(ftag_reg[pend_idx]);
                out_next.writeback_block  = 32'(btag_reg[pend_idx]);
                dirty_next[pend_idx]      = 1'b0;
            end
            if (pend_one && (type_reg == REQ_CLOSE))
            begin
                valid_next = valid_reg & ~fmatch;
            end
        end

        if (cfg_we)
        begin
            lfsr_next = (cfg_data == '0) ? LFSR_ONE : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            lfsr_reg      <= LFSR_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.capture)
        begin
            type_reg  <= req.req_type;
            file_reg  <= FILE_ID_BITS'(req.file_id);
            block_reg <= BLOCK_NUMBER_BITS'(req.block_number);
            full_reg  <= req.full_block;
        end
        if (cmd.victim_prep)
        begin
            quot_reg <= prod[RecipK+15:RecipK];
        end
        if (tag_we)
        begin
            ftag_reg[sel_idx] <= file_reg;
            btag_reg[sel_idx] <= block_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
